FILE: src/pdrf_pkg.sv
package pdrf_pkg;

  localparam int DEFAULT_RING_DEPTH = 1024;
  localparam int QUEUE_DEPTH        = 2;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_STEREO       = 2'd1;

  // sample width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_24 = 2'd2;
  localparam logic [1:0] WIDTH_32 = 2'd3;

  localparam logic [1:0] SAMPLE_WIDTH_RESET = WIDTH_16;
  localparam logic       STEREO_RESET       = 1'b0;

  localparam logic signed [7:0] DENSITY_MIN = -8'sd128;
  localparam logic signed [7:0] DENSITY_MAX = 8'sd127;

  // decoded word handed from the front end to the back end
  typedef struct packed {
    logic              is_write;
    logic              is_tick;
    logic              is_stop;
    logic signed [7:0] sample;
  } op_t;

endpackage

FILE: src/pdrf_front.sv
module pdrf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic signed [31:0]  left_sample,
  input  logic signed [31:0]  right_sample,
  input  logic                q_full,
  output logic                q_push,
  output pdrf_pkg::op_t       q_word
);

  logic [1:0]         sample_width;
  logic               stereo;
  logic               f_valid;
  logic               f_valid_next;
  pdrf_pkg::op_t      f_op;
  pdrf_pkg::op_t      dec_op;
  logic               accept;

  logic signed [31:0] l_ext;
  logic signed [31:0] r_ext;
  logic signed [32:0] l33;
  logic signed [32:0] r33;
  logic signed [32:0] l_half;
  logic signed [32:0] r_half;
  logic signed [32:0] pair_sum;
  logic signed [32:0] pair_avg;
  logic signed [32:0] mix;
  logic signed [32:0] shifted;
  logic signed [7:0]  byte_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width <= pdrf_pkg::SAMPLE_WIDTH_RESET;
      stereo       <= pdrf_pkg::STEREO_RESET;
    end else if (cfg_write) begin
      if (cfg_index == pdrf_pkg::CFG_SAMPLE_WIDTH) begin
        sample_width <= cfg_data;
      end else if (cfg_index == pdrf_pkg::CFG_STEREO) begin
        stereo <= cfg_data[0];
      end
    end
  end

  // sign extend from the configured width
  always_comb begin
    unique case (sample_width)
      pdrf_pkg::WIDTH_8: begin
        l_ext = {{24{left_sample[7]}}, left_sample[7:0]};
        r_ext = {{24{right_sample[7]}}, right_sample[7:0]};
      end
      pdrf_pkg::WIDTH_16: begin
        l_ext = {{16{left_sample[15]}}, left_sample[15:0]};
        r_ext = {{16{right_sample[15]}}, right_sample[15:0]};
      end
      pdrf_pkg::WIDTH_24: begin
        l_ext = {{8{left_sample[23]}}, left_sample[23:0]};
        r_ext = {{8{right_sample[23]}}, right_sample[23:0]};
      end
      default: begin
        l_ext = left_sample;
        r_ext = right_sample;
      end
    endcase
  end

  // halving truncates toward zero: add one to negatives before the shift
  always_comb begin
    l33      = {l_ext[31], l_ext};
    r33      = {r_ext[31], r_ext};
    l_half   = $signed(l33 + {32'd0, l_ext[31]}) >>> 1;
    r_half   = $signed(r33 + {32'd0, r_ext[31]}) >>> 1;
    pair_sum = l33 + r33;
    pair_avg = $signed(pair_sum + {32'd0, pair_sum[32]}) >>> 1;
    if (!stereo) begin
      mix = l33;
    end else if (sample_width == pdrf_pkg::WIDTH_32) begin
      mix = l_half + r_half;
    end else begin
      mix = pair_avg;
    end
    unique case (sample_width)
      pdrf_pkg::WIDTH_8:  shifted = mix;
      pdrf_pkg::WIDTH_16: shifted = mix >>> 8;
      pdrf_pkg::WIDTH_24: shifted = mix >>> 16;
      default:            shifted = mix >>> 24;
    endcase
    if (shifted < 33'(pdrf_pkg::DENSITY_MIN)) begin
      byte_val = pdrf_pkg::DENSITY_MIN;
    end else if (shifted > 33'(pdrf_pkg::DENSITY_MAX)) begin
      byte_val = pdrf_pkg::DENSITY_MAX;
    end else begin
      byte_val = shifted[7:0];
    end
  end

  always_comb begin
    dec_op.is_write = (command == pdrf_pkg::CMD_WRITE);
    dec_op.is_tick  = (command == pdrf_pkg::CMD_TICK);
    dec_op.is_stop  = (command == pdrf_pkg::CMD_STOP);
    dec_op.sample   = byte_val;
  end

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;
  assign q_word   = f_op;

  always_comb begin
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (q_push) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op <= dec_op;
    end
  end

endmodule

FILE: src/pdrf_queue.sv
module pdrf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pdrf_pkg::op_t push_word,
  input  logic          pop,
  output pdrf_pkg::op_t head_word,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(pdrf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pdrf_pkg::QUEUE_DEPTH + 1);

  pdrf_pkg::op_t slots [pdrf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(pdrf_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pdrf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pdrf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/pdrf_back.sv
module pdrf_back #(
  parameter int RING_DEPTH = pdrf_pkg::DEFAULT_RING_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pdrf_pkg::op_t     q_word,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] density,
  output logic              density_valid,
  output logic              dropped,
  output logic              has_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

  logic [7:0]       ring [RING_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp_next;
  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] rp_inc;
  logic [PTR_W-1:0] wp_inc;
  logic             running;
  logic             running_next;
  logic             adv;
  logic             wr_en;
  logic             rd_en;
  logic             drop_now;
  logic             valid_now;

  logic             r_valid;
  logic             r_pop;
  logic             r_density_valid;
  logic             r_dropped;
  logic             r_has_data;

  assign adv    = !q_empty && (!r_valid || !out_stall);
  assign q_pop  = adv;
  assign rp_inc = (rp == LAST) ? '0 : rp + 1'b1;
  assign wp_inc = (wp == LAST) ? '0 : wp + 1'b1;

  always_comb begin
    rp_next      = rp;
    wp_next      = wp;
    running_next = running;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    drop_now     = 1'b0;
    valid_now    = 1'b0;
    if (adv) begin
      if (q_word.is_write) begin
        wr_en        = 1'b1;
        wp_next      = wp_inc;
        running_next = 1'b1;
        // full ring: oldest byte goes
        if (wp_inc == rp) begin
          drop_now = 1'b1;
          rp_next  = rp_inc;
        end
      end else if (q_word.is_tick) begin
        if (running) begin
          valid_now = 1'b1;
          if (rp != wp) begin
            rd_en   = 1'b1;
            rp_next = rp_inc;
          end
        end
      end else if (q_word.is_stop) begin
        rp_next      = '0;
        wp_next      = '0;
        running_next = 1'b0;
        valid_now    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wp] <= q_word.sample;
    end
    if (rd_en) begin
      rd_data <= ring[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp      <= '0;
      wp      <= '0;
      running <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      rp      <= rp_next;
      wp      <= wp_next;
      running <= running_next;
      if (adv) begin
        r_valid <= 1'b1;
      end else if (!out_stall) begin
        r_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_pop           <= rd_en;
      r_density_valid <= valid_now;
      r_dropped       <= drop_now;
      r_has_data      <= (rp_next != wp_next);
    end
  end

  assign out_valid     = r_valid;
  assign density       = r_pop ? $signed(rd_data) : 8'sd0;
  assign density_valid = r_density_valid;
  assign dropped       = r_dropped;
  assign has_data      = r_has_data;

endmodule

FILE: src/pcm_to_density_ring_fifo_core.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_stall  | command, left_sample, right_sample
// output   | out_valid/ out_stall | density, density_valid, dropped, has_data
// config   | cfg_write            | cfg_index, cfg_data (0 sample_width, 1 stereo)
//
// One word per cycle sustained while out_stall is low. An accepted input word passes
// through the front register (decode and requantize), one queue slot, then the ring
// update with the registered ring read feeding the output register.
// rst is synchronous: pointers, running, queue and valids clear; ring contents stay.
// out_stall backs up the two-entry queue; in_stall rises once it and the front
// register are full.
module pcm_to_density_ring_fifo_core #(
  parameter int RING_DEPTH = pdrf_pkg::DEFAULT_RING_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] left_sample,
  input  logic signed [31:0] right_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  density,
  output logic               density_valid,
  output logic               dropped,
  output logic               has_data
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  pdrf_pkg::op_t push_word;
  pdrf_pkg::op_t head_word;

  pdrf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_word       (push_word)
  );

  pdrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head_word (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdrf_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_word        (head_word),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .density       (density),
    .density_valid (density_valid),
    .dropped       (dropped),
    .has_data      (has_data)
  );

endmodule

FILE: dv/tb_pcm_to_density_ring_fifo_core.sv
`timescale 1ns / 100ps

module tb_pcm_to_density_ring_fifo_core;

  localparam int RING_SLOTS    = pdrf_pkg::DEFAULT_RING_DEPTH;
  localparam int PIPE_LATENCY  = 3;
  localparam int SEGMENTS      = 11;
  localparam int SEGMENT_ITEMS = 48;
  localparam int CALM_SEGMENT  = 3;
  localparam int HOLD_SEGMENT  = 5;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 30;

  // codes the block has no name for: they must be ignored
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic signed [7:0] density;
    logic              density_valid;
    logic              dropped;
    logic              has_data;
  } density_word_t;

  typedef struct packed {
    logic          is_cfg;
    logic [1:0]    code;     // command, or register index on a cfg row
    logic [31:0]   left;     // cfg data in the low bits on a cfg row
    logic [31:0]   right;
    logic          known;
    density_word_t want;
  } step_row_t;

  localparam density_word_t QUIET_WORD      = '{8'sd0, 1'b0, 1'b0, 1'b0};
  localparam density_word_t ZERO_VALID_WORD = '{8'sd0, 1'b1, 1'b0, 1'b0};
  localparam density_word_t WRITE_WORD      = '{8'sd0, 1'b0, 1'b0, 1'b1};
  localparam density_word_t POP_MAX_WORD    = '{8'sd127, 1'b1, 1'b0, 1'b1};
  localparam density_word_t POP_MIN_WORD    = '{-8'sd128, 1'b1, 1'b0, 1'b1};

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [1:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [31:0] left_sample;
  logic signed [31:0] right_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [7:0]  density;
  logic               density_valid;
  logic               dropped;
  logic               has_data;

  pcm_to_density_ring_fifo_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .density      (density),
    .density_valid(density_valid),
    .dropped      (dropped),
    .has_data     (has_data)
  );

  // shadow of the block's state
  logic signed [7:0] ring_bytes [RING_SLOTS];
  int                rd_slot;
  int                wr_slot;
  logic              ring_running;
  logic [1:0]        cur_width;
  logic              cur_stereo;

  density_word_t density_due[$];

  int  errors;
  int  words_checked;
  int  drops_seen;
  int  pops_seen;
  int  items_sent;
  int  reg_writes;
  int  cycle_count;
  int  stall_cycles;
  int  hold_requests;
  int  hold_served;
  int  hold_left;
  bit  calm;

  step_row_t directed_steps [DIRECTED_ROWS] = '{
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b1, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_STOP,  32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_VALID_WORD},
    '{1'b0, CMD_UNUSED,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h0000_7FFF, 32'h0000_0000, 1'b1, WRITE_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'hFFFF_8000, 32'hFFFF_FFFF, 1'b1, WRITE_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'hABCD_0180, 32'h5555_5555, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h1234_FF7F, 32'hAAAA_AAAA, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b1, POP_MAX_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, POP_MIN_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_VALID_WORD},
    '{1'b1, pdrf_pkg::CFG_SAMPLE_WIDTH, 32'(pdrf_pkg::WIDTH_8), 32'h0, 1'b0, QUIET_WORD},
    '{1'b1, pdrf_pkg::CFG_STEREO,       32'h1,                  32'h0, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h0000_007F, 32'h0000_007F, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'hFFFF_FF80, 32'h0000_007F, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'hFFFF_FFFD, 32'h0000_0000, 1'b0, QUIET_WORD},
    '{1'b1, pdrf_pkg::CFG_SAMPLE_WIDTH, 32'(pdrf_pkg::WIDTH_32), 32'h0, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h8000_0000, 32'h8000_0000, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h8000_0001, 32'h0000_0001, 1'b0, QUIET_WORD},
    '{1'b1, pdrf_pkg::CFG_SAMPLE_WIDTH, 32'(pdrf_pkg::WIDTH_24), 32'h0, 1'b0, QUIET_WORD},
    '{1'b1, pdrf_pkg::CFG_STEREO,       32'h2,                   32'h0, 1'b0, QUIET_WORD},
    '{1'b1, CFG_UNUSED_2,               32'h3,                   32'h0, 1'b0, QUIET_WORD},
    '{1'b1, CFG_UNUSED_3,               32'h1,                   32'h0, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_WRITE, 32'h0080_0000, 32'hFFFF_FFFF, 1'b0, QUIET_WORD},
    '{1'b0, CMD_UNUSED,          32'h1234_5678, 32'h8765_4321, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b0, QUIET_WORD},
    '{1'b0, pdrf_pkg::CMD_STOP,  32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_VALID_WORD},
    '{1'b0, pdrf_pkg::CMD_TICK,  32'h0000_0000, 32'h0000_0000, 1'b1, QUIET_WORD}
  };

  function automatic logic signed [7:0] requantize_pcm(logic [31:0] l, logic [31:0] r);
    longint lx;
    longint rx;
    longint mix;
    unique case (cur_width)
      pdrf_pkg::WIDTH_8: begin
        lx = longint'($signed(l[7:0]));
        rx = longint'($signed(r[7:0]));
      end
      pdrf_pkg::WIDTH_16: begin
        lx = longint'($signed(l[15:0]));
        rx = longint'($signed(r[15:0]));
      end
      pdrf_pkg::WIDTH_24: begin
        lx = longint'($signed(l[23:0]));
        rx = longint'($signed(r[23:0]));
      end
      default: begin
        lx = longint'($signed(l));
        rx = longint'($signed(r));
      end
    endcase
    // division truncates toward zero; 32-bit channels are halved first
    if (cur_stereo) begin
      if (cur_width == pdrf_pkg::WIDTH_32) mix = lx / 2 + rx / 2;
      else mix = (lx + rx) / 2;
    end else begin
      mix = lx;
    end
    mix = mix >>> (8 * cur_width);
    if (mix < pdrf_pkg::DENSITY_MIN) mix = longint'(pdrf_pkg::DENSITY_MIN);
    if (mix > pdrf_pkg::DENSITY_MAX) mix = longint'(pdrf_pkg::DENSITY_MAX);
    return mix[7:0];
  endfunction

  function automatic density_word_t predict_density_word(logic [1:0] cmd, logic [31:0] l,
                                                         logic [31:0] r);
    density_word_t w;
    int            nxt;
    w = QUIET_WORD;
    unique case (cmd)
      pdrf_pkg::CMD_WRITE: begin
        nxt = (wr_slot + 1) % RING_SLOTS;
        // full ring: oldest byte goes
        if (nxt == rd_slot) begin
          rd_slot   = (rd_slot + 1) % RING_SLOTS;
          w.dropped = 1'b1;
        end
        ring_bytes[wr_slot] = requantize_pcm(l, r);
        wr_slot = nxt;
        ring_running = 1'b1;
      end
      pdrf_pkg::CMD_TICK: begin
        if (ring_running) begin
          w.density_valid = 1'b1;
          if (rd_slot != wr_slot) begin
            w.density = ring_bytes[rd_slot];
            rd_slot   = (rd_slot + 1) % RING_SLOTS;
          end
        end
      end
      pdrf_pkg::CMD_STOP: begin
        rd_slot = 0;
        wr_slot = 0;
        ring_running = 1'b0;
        w.density_valid = 1'b1;
      end
      default: ;
    endcase
    w.has_data = (rd_slot != wr_slot);
    return w;
  endfunction

  function automatic logic [1:0] random_command();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 52) return pdrf_pkg::CMD_WRITE;
    if (p < 90) return pdrf_pkg::CMD_TICK;
    if (p < 95) return pdrf_pkg::CMD_STOP;
    return CMD_UNUSED;
  endfunction

  // half full random, with the width's extremes and values near zero mixed in
  function automatic logic [31:0] random_sample();
    logic [31:0] top;
    top = 32'h7FFF_FFFF >> (8 * (3 - cur_width));
    case ($urandom_range(0, 5))
      3: return top;
      4: return ~top;
      5: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("%0t: word %0d: %s got %0d want %0d", $realtime, words_checked, field, got, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (density_due.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == pdrf_pkg::CFG_SAMPLE_WIDTH) cur_width = data;
    else if (idx == pdrf_pkg::CFG_STEREO) cur_stereo = data[0];
    reg_writes++;
  endtask

  task automatic drive_word(input logic [1:0] cmd, input logic [31:0] l, input logic [31:0] r,
                            input logic known, input density_word_t typed);
    density_word_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    left_sample  <= l;
    right_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_density_word(cmd, l, r);
    density_due.push_back(known ? typed : predicted);
    items_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_stall) stall_cycles <= stall_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               density_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    density_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (density_due.size() == 0) begin
        report_mismatch("unexpected word, density", int'(density), 0);
      end else begin
        want = density_due.pop_front();
        if (density !== want.density)
          report_mismatch("density", int'(density), int'(want.density));
        if (density_valid !== want.density_valid)
          report_mismatch("density_valid", int'(density_valid), int'(want.density_valid));
        if (dropped !== want.dropped)
          report_mismatch("dropped", int'(dropped), int'(want.dropped));
        if (has_data !== want.has_data)
          report_mismatch("has_data", int'(has_data), int'(want.has_data));
      end
      words_checked++;
      if (dropped) drops_seen++;
      if (density_valid) pops_seen++;
    end
  end

  // receiver: random stalls, plus one long hold on request from the sender
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= !rst && !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  initial begin
    step_row_t row;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = pdrf_pkg::CFG_SAMPLE_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    command      = pdrf_pkg::CMD_WRITE;
    left_sample  = '0;
    right_sample = '0;
    rd_slot      = 0;
    wr_slot      = 0;
    ring_running = 1'b0;
    cur_width    = pdrf_pkg::SAMPLE_WIDTH_RESET;
    cur_stereo   = pdrf_pkg::STEREO_RESET;
    calm         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_cfg) write_reg(row.code, row.left[1:0]);
      else drive_word(row.code, row.left, row.right, row.known, row.want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_reg(pdrf_pkg::CFG_SAMPLE_WIDTH, 2'($urandom_range(0, 3)));
      write_reg(pdrf_pkg::CFG_STEREO, 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        write_reg(2'($urandom_range(CFG_UNUSED_2, CFG_UNUSED_3)), 2'($urandom_range(0, 3)));
      calm = (seg == CALM_SEGMENT);
      if (seg == HOLD_SEGMENT) hold_requests++;
      repeat (SEGMENT_ITEMS)
        drive_word(random_command(), random_sample(), random_sample(), 1'b0, QUIET_WORD);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (density_due.size() != 0) @(posedge clk);
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    $display("%0d words sent and %0d checked across %0d register writes",
             items_sent, words_checked, reg_writes);
    $display("%0d densities given, %0d overwrites, input held off %0d cycles",
             pops_seen, drops_seen, stall_cycles);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/pdrf_pkg.sv
src/pdrf_front.sv
src/pdrf_queue.sv
src/pdrf_back.sv
src/pcm_to_density_ring_fifo_core.sv
dv/tb_pcm_to_density_ring_fifo_core.sv
